>>> rtl/ble_pkg.sv
package ble_pkg;

  // Sizing
  localparam int MAX_LEN     = 8192;
  localparam int WINDOW      = 50;
  localparam int SAMPLE_BITS = 16;

  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int MAG_W  = 2 * SAMPLE_BITS;
  localparam int SUM_W  = MAG_W + $clog2(WINDOW);

  // Register and result field widths
  localparam int SS_W       = 13;
  localparam int PAD_W      = 10;
  localparam int SHIFT_W    = 4;
  localparam int EST_W      = 15;
  localparam int TOT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int SHIFT_MAX = (1 << SHIFT_W) - 1;
  localparam int CMP_W     = SUM_W + SHIFT_MAX;

  // Register reset values
  localparam logic [SS_W-1:0]    SEARCH_START_RST = SS_W'(1000);
  localparam logic [PAD_W-1:0]   TAIL_PAD_RST     = PAD_W'(100);
  localparam logic [SHIFT_W-1:0] THRESH_SHIFT_RST = SHIFT_W'(4);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_START = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_PAD     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_SHIFT = CFG_IDX_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_I,
    ST_SQ_Q,
    ST_UPD,
    ST_PEAK,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_DONE
  } state_t;

  // Control for the shared squaring unit
  typedef struct packed {
    logic sq_i;  // square I into the partial register
    logic sq_q;  // square Q and add the partial
  } mag_ctl_t;

endpackage

>>> rtl/burst_length_estimator.sv
// Per sample: accepted in IDLE, then square I, square Q, sum update, store/peak
// before the next transaction; store/peak is skipped while the window fills or
// the store is full. On the marked sample the window store is scanned from
// search_start, a RAM read and a compare per index, one more step when no end
// is found, then the result register is loaded. Reset (synchronous, rst_n low)
// clears counters, totals and handshakes and restores register defaults.
module burst_length_estimator (
  input  logic                                   clk,
  input  logic                                   rst_n,

  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [ble_pkg::SAMPLE_BITS-1:0] in_sample_i,
  input  logic signed [ble_pkg::SAMPLE_BITS-1:0] in_sample_q,
  input  logic                                   in_last,

  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_kept,
  output logic [ble_pkg::EST_W-1:0]              out_est_len,
  output logic [ble_pkg::CNT_W-1:0]              out_stored_len,
  output logic [ble_pkg::TOT_W-1:0]              out_good_count,
  output logic [ble_pkg::TOT_W-1:0]              out_bad_count,
  output logic                                   out_truncated,

  input  logic                                   cfg_we,
  input  logic [ble_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ble_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  ble_pkg::state_t state_r, state_nxt;

  // configuration
  logic [ble_pkg::SS_W-1:0]    ss_r;
  logic [ble_pkg::PAD_W-1:0]   pad_r;
  logic [ble_pkg::SHIFT_W-1:0] shift_r;

  // per-burst control
  logic [ble_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [ble_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [ble_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [ble_pkg::SUM_W-1:0]  peak_r, peak_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [ble_pkg::CNT_W-1:0]  k_r, k_nxt;
  logic                       kept_r, kept_nxt;
  logic [ble_pkg::EST_W-1:0]  est_r, est_nxt;

  // totals
  logic [ble_pkg::TOT_W-1:0] acc_r, acc_nxt;
  logic [ble_pkg::TOT_W-1:0] dis_r, dis_nxt;

  // captured transaction
  logic signed [ble_pkg::SAMPLE_BITS-1:0] i_r, q_r;
  logic                                   last_r;

  // result register
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_kept_r;
  logic [ble_pkg::EST_W-1:0] out_est_r;
  logic [ble_pkg::CNT_W-1:0] out_orig_r;
  logic [ble_pkg::TOT_W-1:0] out_good_r, out_bad_r;
  logic                      out_trunc_r;
  logic                      out_load;

  // memories
  logic [ble_pkg::MAG_W-1:0] mag_delay [ble_pkg::WINDOW];
  logic [ble_pkg::MAG_W-1:0] old_r;       // magnitude leaving the window
  logic [ble_pkg::SUM_W-1:0] win_store [ble_pkg::MAX_LEN];
  logic [ble_pkg::SUM_W-1:0] rd_r;        // window sum under test

  logic                       accept;
  logic                       dly_wr;
  logic                       st_wr;
  logic                       st_rd;
  logic [ble_pkg::ADDR_W-1:0] st_waddr;

  ble_pkg::mag_ctl_t         mag_ctl;
  logic [ble_pkg::MAG_W-1:0] mag;

  // datapath helpers
  logic                      store_full;
  logic                      warm;
  logic                      in_range;
  logic [ble_pkg::CMP_W-1:0] thr_lhs;
  logic                      below;
  logic                      finish;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state_r != ble_pkg::ST_IDLE);

  assign store_full = (count_r >= ble_pkg::CNT_W'(ble_pkg::MAX_LEN));
  assign warm       = (count_r >= ble_pkg::CNT_W'(ble_pkg::WINDOW));
  // k < count - WINDOW, safe also when count <= WINDOW
  assign in_range   = ((k_r + ble_pkg::CNT_W'(ble_pkg::WINDOW)) < count_r);
  // exact threshold test: (sum << shift) < peak
  assign thr_lhs    = ble_pkg::CMP_W'(rd_r) << shift_r;
  assign below      = (thr_lhs < ble_pkg::CMP_W'(peak_r));
  assign st_waddr   = ble_pkg::ADDR_W'(count_r - ble_pkg::CNT_W'(ble_pkg::WINDOW));

  assign out_load   = (state_r == ble_pkg::ST_DONE) && (!out_valid_r || !out_stall);

  // ---------------------------------------------------------------------------
  // Shared squaring unit
  // ---------------------------------------------------------------------------
  ble_mag_unit u_mag (
    .clk      (clk),
    .ctl      (mag_ctl),
    .sample_i (i_r),
    .sample_q (q_r),
    .mag      (mag)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ble_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    slot_nxt      = slot_r;
    sum_nxt       = sum_r;
    peak_nxt      = peak_r;
    ovf_nxt       = ovf_r;
    k_nxt         = k_r;
    kept_nxt      = kept_r;
    est_nxt       = est_r;
    acc_nxt       = acc_r;
    dis_nxt       = dis_r;
    out_valid_nxt = out_valid_r;
    mag_ctl       = '0;
    dly_wr        = 1'b0;
    st_wr         = 1'b0;
    st_rd         = 1'b0;
    finish        = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ble_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = ble_pkg::ST_SQ_I;
        end
      end

      ble_pkg::ST_SQ_I: begin
        mag_ctl.sq_i = 1'b1;
        state_nxt    = ble_pkg::ST_SQ_Q;
      end

      ble_pkg::ST_SQ_Q: begin
        mag_ctl.sq_q = 1'b1;
        state_nxt    = ble_pkg::ST_UPD;
      end

      ble_pkg::ST_UPD: begin
        if (store_full) begin
          // dropped sample, a marked one still ends the burst
          ovf_nxt = 1'b1;
          finish  = 1'b1;
        end else begin
          dly_wr   = 1'b1;
          slot_nxt = (slot_r == ble_pkg::SLOT_W'(ble_pkg::WINDOW - 1)) ?
                     '0 : slot_r + 1'b1;
          if (warm) begin
            sum_nxt   = sum_r + ble_pkg::SUM_W'(mag) - ble_pkg::SUM_W'(old_r);
            state_nxt = ble_pkg::ST_PEAK;
          end else begin
            sum_nxt   = sum_r + ble_pkg::SUM_W'(mag);
            count_nxt = count_r + 1'b1;
            finish    = 1'b1;
          end
        end
      end

      ble_pkg::ST_PEAK: begin
        st_wr     = 1'b1;
        count_nxt = count_r + 1'b1;
        if (sum_r > peak_r) begin
          peak_nxt = sum_r;
        end
        finish = 1'b1;
      end

      ble_pkg::ST_SCAN_RD: begin
        if (in_range) begin
          st_rd     = 1'b1;
          state_nxt = ble_pkg::ST_SCAN_CMP;
        end else begin
          // no end found
          kept_nxt  = 1'b0;
          state_nxt = ble_pkg::ST_DONE;
        end
      end

      ble_pkg::ST_SCAN_CMP: begin
        if (below) begin
          // an end right at search_start counts as discarded
          kept_nxt  = (k_r > ble_pkg::CNT_W'(ss_r));
          est_nxt   = ble_pkg::EST_W'(k_r) + ble_pkg::EST_W'(ss_r) +
                      ble_pkg::EST_W'(pad_r);
          state_nxt = ble_pkg::ST_DONE;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ble_pkg::ST_SCAN_RD;
        end
      end

      ble_pkg::ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if (kept_r) begin
            acc_nxt = acc_r + 1'b1;
          end else begin
            dis_nxt = dis_r + 1'b1;
          end
          count_nxt = '0;
          slot_nxt  = '0;
          sum_nxt   = '0;
          peak_nxt  = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ble_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ble_pkg::ST_IDLE;
      end
    endcase

    if (finish) begin
      if (last_r) begin
        k_nxt     = ble_pkg::CNT_W'(ss_r);
        state_nxt = ble_pkg::ST_SCAN_RD;
      end else begin
        state_nxt = ble_pkg::ST_IDLE;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      slot_r      <= '0;
      sum_r       <= '0;
      peak_r      <= '0;
      ovf_r       <= 1'b0;
      k_r         <= '0;
      kept_r      <= 1'b0;
      acc_r       <= '0;
      dis_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      slot_r      <= slot_nxt;
      sum_r       <= sum_nxt;
      peak_r      <= peak_nxt;
      ovf_r       <= ovf_nxt;
      k_r         <= k_nxt;
      kept_r      <= kept_nxt;
      acc_r       <= acc_nxt;
      dis_r       <= dis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ss_r    <= ble_pkg::SEARCH_START_RST;
      pad_r   <= ble_pkg::TAIL_PAD_RST;
      shift_r <= ble_pkg::THRESH_SHIFT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ble_pkg::CFG_SEARCH_START: ss_r    <= cfg_wdata[ble_pkg::SS_W-1:0];
        ble_pkg::CFG_TAIL_PAD:     pad_r   <= cfg_wdata[ble_pkg::PAD_W-1:0];
        ble_pkg::CFG_THRESH_SHIFT: shift_r <= cfg_wdata[ble_pkg::SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    est_r <= est_nxt;
    if (accept) begin
      i_r    <= in_sample_i;
      q_r    <= in_sample_q;
      last_r <= in_last;
    end
    if (out_load) begin
      out_kept_r  <= kept_r;
      out_est_r   <= kept_r ? est_r : '0;
      out_orig_r  <= count_r;
      out_good_r  <= acc_nxt;
      out_bad_r   <= dis_nxt;
      out_trunc_r <= ovf_r;
    end
  end

  // magnitude delay line: slot read on accept, same slot written back in UPD
  always_ff @(posedge clk) begin
    if (accept) begin
      old_r <= mag_delay[slot_r];
    end
    if (dly_wr) begin
      mag_delay[slot_r] <= mag;
    end
  end

  // window sum store: single port, write while loading, read while scanning
  always_ff @(posedge clk) begin
    if (st_wr) begin
      win_store[st_waddr] <= sum_r;
    end
    if (st_rd) begin
      rd_r <= win_store[k_r[ble_pkg::ADDR_W-1:0]];
    end
  end

  // ---------------------------------------------------------------------------
  // Result channel
  // ---------------------------------------------------------------------------
  assign out_valid      = out_valid_r;
  assign out_kept       = out_kept_r;
  assign out_est_len    = out_est_r;
  assign out_stored_len = out_orig_r;
  assign out_good_count = out_good_r;
  assign out_bad_count  = out_bad_r;
  assign out_truncated  = out_trunc_r;

endmodule

>>> rtl/ble_mag_unit.sv
// One signed multiplier, used twice per sample: I*I, then Q*Q + partial.
module ble_mag_unit (
  input  logic                                clk,
  input  ble_pkg::mag_ctl_t                   ctl,
  input  logic signed [ble_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic signed [ble_pkg::SAMPLE_BITS-1:0] sample_q,
  output logic [ble_pkg::MAG_W-1:0]           mag
);

  logic signed [ble_pkg::SAMPLE_BITS-1:0] op;
  logic signed [ble_pkg::MAG_W-1:0]       prod;
  logic [ble_pkg::MAG_W-2:0]              sq_abs;
  logic [ble_pkg::MAG_W-2:0]              sq_r;
  logic [ble_pkg::MAG_W-1:0]              mag_r;

  assign op     = ctl.sq_q ? sample_q : sample_i;
  assign prod   = op * op;
  assign sq_abs = prod[ble_pkg::MAG_W-2:0];  // square is never negative
  assign mag    = mag_r;

  always_ff @(posedge clk) begin
    if (ctl.sq_i) begin
      sq_r <= sq_abs;
    end
    if (ctl.sq_q) begin
      mag_r <= {1'b0, sq_r} + {1'b0, sq_abs};
    end
  end

endmodule
